FILE: sv/ple_pkg.sv
package ple_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int GRP_SIZE = 8;
    localparam int GRP_NUM  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    // request kinds
    localparam logic [2:0] KIND_READ   = 3'd0;
    localparam logic [2:0] KIND_FRONT  = 3'd1;
    localparam logic [2:0] KIND_BACK   = 3'd2;
    localparam logic [2:0] KIND_AT     = 3'd3;
    localparam logic [2:0] KIND_DELETE = 3'd4;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } cell_op_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t            op;
        logic [IDX_W-1:0]    pos;
        logic [DATA_W-1:0]   value;
        logic                read_en;
        logic [IDX_W-1:0]    read_pos;
    } cell_ctrl_t;

endpackage

FILE: sv/ple_cell.sv
module ple_cell (
    input  logic                        clk,
    input  ple_pkg::cell_ctrl_t         ctrl,
    input  logic [ple_pkg::IDX_W-1:0]   cell_idx,
    input  logic [ple_pkg::DATA_W-1:0]  from_left,
    input  logic [ple_pkg::DATA_W-1:0]  from_right,
    output logic [ple_pkg::DATA_W-1:0]  value_q,
    output logic [ple_pkg::DATA_W-1:0]  leaf
);
    import ple_pkg::*;

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic [DATA_W-1:0] leaf_reg;
    logic [DATA_W-1:0] leaf_next;

    // shift up on insert, down on delete
    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                if (cell_idx > ctrl.pos)
                    value_next = from_left;
                else if (cell_idx == ctrl.pos)
                    value_next = ctrl.value;
            end
            CELL_DELETE:
            begin
                if (cell_idx >= ctrl.pos)
                    value_next = from_right;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // read leaf: own value when selected, zero otherwise
    always_comb
    begin
        if (ctrl.read_en && (cell_idx == ctrl.read_pos))
            leaf_next = value_reg;
        else
            leaf_next = '0;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        leaf_reg  <= leaf_next;
    end

    assign value_q = value_reg;
    assign leaf    = leaf_reg;

endmodule

FILE: sv/ple_or_tree.sv
module ple_or_tree (
    input  logic                        clk,
    input  logic [ple_pkg::DATA_W-1:0]  leaves [ple_pkg::CAPACITY],
    output logic [ple_pkg::DATA_W-1:0]  result
);
    import ple_pkg::*;

    logic [DATA_W-1:0] group_reg  [GRP_NUM];
    logic [DATA_W-1:0] group_next [GRP_NUM];

    // first level: groups of leaves
    always_comb
    begin
        for (int g = 0; g < GRP_NUM; g++)
        begin
            group_next[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++)
            begin
                if (g * GRP_SIZE + j < CAPACITY)
                    group_next[g] = group_next[g] | leaves[g * GRP_SIZE + j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < GRP_NUM; g++)
            group_reg[g] <= group_next[g];
    end

    // second level: combine the group registers
    always_comb
    begin
        result = '0;
        for (int g = 0; g < GRP_NUM; g++)
            result = result | group_reg[g];
    end

endmodule

FILE: sv/positional_list_engine.sv
// done strobes after the accepted request has gone through S_LEAF and S_TREE;
// busy is high in those states, spent in the two-level registered read-out
// OR tree over the cells, so no new request is taken until busy falls.
// The receiver cannot stall: each result is on the ports for one cycle.
// Reset clears the entry count and control; cell contents are not reset.
module positional_list_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         kind,
    input  logic signed [15:0]                 position,
    input  logic signed [31:0]                 item_value,
    output logic                               done,
    output logic [1:0]                         status,
    output logic signed [31:0]                 read_value,
    output logic [6:0]                         entry_count
);
    import ple_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEAF,
        S_TREE
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic               hit_reg;
    logic               hit_next;
    logic               done_reg;
    logic [DATA_W-1:0]  read_value_reg;

    cell_ctrl_t         ctrl;
    logic               accept;
    logic               pos_neg;
    logic [15:0]        pos_mag;
    logic [15:0]        cnt_ext;
    logic               in_range;
    logic               pos_le_cnt;
    logic               full;
    logic [DATA_W-1:0]  tree_out;

    logic [DATA_W-1:0]  cell_q [CAPACITY];
    logic [DATA_W-1:0]  leaves [CAPACITY];

    assign accept     = start && (state_reg == S_IDLE);
    assign pos_neg    = position[15];
    assign pos_mag    = position;
    assign cnt_ext    = 16'(count_reg);
    assign in_range   = !pos_neg && (pos_mag < cnt_ext);
    assign pos_le_cnt = !pos_neg && (pos_mag <= cnt_ext);
    assign full       = (count_reg == CNT_W'(CAPACITY));

    // request decode
    always_comb
    begin
        ctrl.op       = CELL_HOLD;
        ctrl.pos      = '0;
        ctrl.value    = item_value;
        ctrl.read_en  = 1'b0;
        ctrl.read_pos = position[IDX_W-1:0];
        status_next   = ST_RANGE;
        count_next    = count_reg;
        hit_next      = 1'b0;
        if (accept)
        begin
            unique case (kind)
                KIND_READ:
                begin
                    if (in_range)
                    begin
                        ctrl.read_en = 1'b1;
                        hit_next     = 1'b1;
                        status_next  = ST_DONE;
                    end
                end
                KIND_FRONT:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        ctrl.op     = CELL_INSERT;
                        ctrl.pos    = '0;
                        count_next  = count_reg + CNT_W'(1);
                        status_next = ST_DONE;
                    end
                end
                KIND_BACK:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        ctrl.op     = CELL_INSERT;
                        ctrl.pos    = count_reg[IDX_W-1:0];
                        count_next  = count_reg + CNT_W'(1);
                        status_next = ST_DONE;
                    end
                end
                KIND_AT:
                begin
                    if (!pos_neg && !pos_le_cnt)
                        status_next = ST_RANGE;
                    else if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        ctrl.op     = CELL_INSERT;
                        ctrl.pos    = pos_neg ? '0 : position[IDX_W-1:0];
                        count_next  = count_reg + CNT_W'(1);
                        status_next = ST_DONE;
                    end
                end
                KIND_DELETE:
                begin
                    if (in_range)
                    begin
                        ctrl.op     = CELL_DELETE;
                        ctrl.pos    = position[IDX_W-1:0];
                        count_next  = count_reg - CNT_W'(1);
                        status_next = ST_DONE;
                    end
                end
                default:
                begin
                    status_next = ST_RANGE;
                end
            endcase
        end
    end

    // row of cells, each linked to both neighbors
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_val;
        logic [DATA_W-1:0] right_val;

        if (g == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_mid_l
            assign left_val = cell_q[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_val = '0;
        end
        else
        begin : g_mid_r
            assign right_val = cell_q[g+1];
        end

        ple_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .cell_idx   (IDX_W'(g)),
            .from_left  (left_val),
            .from_right (right_val),
            .value_q    (cell_q[g]),
            .leaf       (leaves[g])
        );
    end

    ple_or_tree u_tree (
        .clk    (clk),
        .leaves (leaves),
        .result (tree_out)
    );

    // sequencer, count and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            status_reg     <= ST_DONE;
            hit_reg        <= 1'b0;
            done_reg       <= 1'b0;
            read_value_reg <= '1;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg  <= count_next;
                        status_reg <= status_next;
                        hit_reg    <= hit_next;
                        state_reg  <= S_LEAF;
                    end
                end
                S_LEAF:
                begin
                    state_reg <= S_TREE;
                end
                S_TREE:
                begin
                    read_value_reg <= hit_reg ? tree_out : '1;
                    done_reg       <= 1'b1;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign entry_count = 7'(count_reg);

    // every accepted request is followed by its result strobe
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result strobe missing after accepted request");

    // a result strobe is never followed directly by another
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result strobes");

    // count never passes the store size
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // count moves by at most one, and only on an accepted request
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> $stable(count_reg))
        else $error("entry count changed without a request");

endmodule

FILE: dv/positional_list_checker.sv
`timescale 1ns / 100ps

// Watches the request and result channels of the list engine, keeps its own
// copy of the ordered list and checks every result against it.
module positional_list_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         kind,
    input  logic signed [15:0] position,
    input  logic signed [31:0] item_value,
    input  logic               done,
    input  logic [1:0]         status,
    input  logic signed [31:0] read_value,
    input  logic [6:0]         entry_count,
    output int                 fail_count,
    output int                 pending
);
    import ple_pkg::*;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [6:0]         entry_count;
    } outcome_t;

    // shadow of the list contents
    logic signed [31:0] list_mem [CAPACITY];
    int                 list_len;
    outcome_t           expected_results [$];

    // shift up from idx and place the value; a full list changes nothing
    function automatic logic [1:0] insert_at(input int idx, input logic signed [31:0] v);
        int i;
        if (list_len >= CAPACITY)
            return ST_FULL;
        for (i = list_len; i > idx; i--)
            list_mem[i] = list_mem[i - 1];
        list_mem[idx] = v;
        list_len++;
        return ST_DONE;
    endfunction

    // apply one request to the shadow list and return its outcome
    function automatic outcome_t apply_request(
        input logic [2:0]         k,
        input logic signed [15:0] p,
        input logic signed [31:0] v
    );
        outcome_t res;
        int       pos;
        int       i;
        pos            = int'(p);
        res.status     = ST_DONE;
        res.read_value = -1;
        case (k)
            KIND_READ: begin
                if (pos < 0 || pos >= list_len)
                    res.status = ST_RANGE;
                else
                    res.read_value = list_mem[pos];
            end
            KIND_FRONT:
                res.status = insert_at(0, v);
            KIND_BACK:
                res.status = insert_at(list_len, v);
            KIND_AT: begin
                // negative goes to the front; past the end is ignored even when full
                if (pos < 0)
                    res.status = insert_at(0, v);
                else if (pos > list_len)
                    res.status = ST_RANGE;
                else
                    res.status = insert_at(pos, v);
            end
            KIND_DELETE: begin
                if (pos < 0 || pos >= list_len) begin
                    res.status = ST_RANGE;
                end
                else begin
                    for (i = pos; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
            default:
                res.status = ST_RANGE;
        endcase
        res.entry_count = 7'(list_len);
        return res;
    endfunction

    // compare results first, then record the request taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n) begin
            list_len = 0;
            expected_results.delete();
            fail_count = 0;
            pending    = 0;
        end
        else begin
            if (done) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: %s %0d %s %0d %s %0d",
                           "status", status, "read_value", read_value,
                           "count", entry_count);
                    fail_count++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d", want.read_value, read_value);
                        fail_count++;
                    end
                    if (entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, entry_count);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_request(kind, position, item_value));
            pending = expected_results.size();
        end
    end

endmodule

FILE: dv/tb_positional_list_engine.sv
`timescale 1ns / 100ps

// Drives requests into the list engine: a directed opening over the edge
// cases, then random grow and shrink phases that fill the list to capacity
// and drain it again. Results are checked by the checker beside the block.
module tb_positional_list_engine;

    import ple_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int PHASE_LEN    = 120;
    localparam int DRAIN_CYCLES = 8;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         kind;
    logic signed [15:0] position;
    logic signed [31:0] item_value;
    logic               done;
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         entry_count;
    int                 fail_count;
    int                 pending;
    int                 level;

    positional_list_engine i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .position    (position),
        .item_value  (item_value),
        .done        (done),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

    positional_list_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .position    (position),
        .item_value  (item_value),
        .done        (done),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // last reported list length, used only to aim positions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level <= 0;
        else if (done)
            level <= int'(entry_count);
    end

    // one request transfer; entered and left at a falling edge
    task automatic send(
        input logic [2:0]         k,
        input logic signed [15:0] p,
        input logic signed [31:0] v,
        input int                 gap
    );
        if (gap > 0) begin
            start      <= 1'b0;
            kind       <= 3'($urandom);
            position   <= 16'($urandom);
            item_value <= $urandom;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        kind       <= k;
        position   <= p;
        item_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random request shaped by the current phase
    task automatic send_random(input int n);
        logic [2:0]         k;
        logic signed [15:0] p;
        int                 r;
        int                 ins_pct;
        int                 gap;
        bit                 grow;
        grow    = ((n / PHASE_LEN) % 2) == 0;
        ins_pct = grow ? 85 : 20;
        r       = $urandom_range(0, 99);
        if (r < 3)
            k = 3'(KIND_DELETE + $urandom_range(1, 3));
        else if (r < 3 + ins_pct)
            k = 3'(KIND_FRONT + $urandom_range(0, 2));
        else if (r < 3 + ins_pct + (grow ? 10 : 15))
            k = KIND_READ;
        else
            k = KIND_DELETE;

        case ($urandom_range(0, 9))
            0:       p = 16'($urandom);
            1:       p = -16'($urandom_range(1, 3));
            default: p = 16'($urandom_range(0, level + 1));
        endcase

        // every third block of forty runs back to back
        gap = (((n / 40) % 3) == 1) ? 0 : $urandom_range(0, 13);
        send(k, p, $urandom, gap);
    endtask

    // directed opening
    task automatic run_directed();
        // empty list
        send(KIND_READ, 16'sd0, 32'sd7, $urandom_range(0, 13));
        send(KIND_DELETE, 16'sd0, 32'sd7, $urandom_range(0, 13));
        send(KIND_AT, 16'sd1, 32'sd7, $urandom_range(0, 13));
        // every insert form, extreme values
        send(KIND_AT, -16'sd1, 32'sh8000_0000, 0);
        send(KIND_FRONT, 16'sd0, 32'sh7FFF_FFFF, 0);
        send(KIND_BACK, 16'sd9, -32'sd1, $urandom_range(0, 13));
        send(KIND_AT, 16'sd3, 32'sd0, $urandom_range(0, 13));
        send(KIND_AT, 16'sd1, 32'sh5555_5555, 0);
        send(KIND_AT, 16'sh7FFF, 32'sd1, $urandom_range(0, 13));
        send(KIND_AT, 16'sh8000, 32'shAAAA_AAAA, 0);
        // reads at both ends and out of range
        send(KIND_READ, 16'sd0, 32'sd0, 0);
        send(KIND_READ, 16'sd5, 32'sd0, $urandom_range(0, 13));
        send(KIND_READ, 16'sd6, 32'sd0, 0);
        send(KIND_READ, -16'sd1, 32'sd0, 0);
        send(KIND_READ, 16'sh8000, 32'sd0, $urandom_range(0, 13));
        send(KIND_READ, 16'sh7FFF, 32'sd0, 0);
        // deletes out of range, then at front, back and middle
        send(KIND_DELETE, -16'sd1, 32'sd0, 0);
        send(KIND_DELETE, 16'sh7FFF, 32'sd0, $urandom_range(0, 13));
        send(KIND_DELETE, 16'sd6, 32'sd0, 0);
        send(KIND_DELETE, 16'sd0, 32'sd0, 0);
        send(KIND_DELETE, 16'sd4, 32'sd0, $urandom_range(0, 13));
        send(KIND_DELETE, 16'sd1, 32'sd0, 0);
        // unused kinds
        send(3'(KIND_DELETE + 1), 16'sd0, 32'sd3, 0);
        send(3'(KIND_DELETE + 2), 16'sd0, 32'sd3, $urandom_range(0, 13));
        send(3'(KIND_DELETE + 3), 16'sd0, 32'sd3, 0);
    endtask

    initial
    begin
        start      = 1'b0;
        kind       = KIND_READ;
        position   = '0;
        item_value = '0;
        rst_n      = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_random(n);
        start <= 1'b0;

        // drain outstanding results
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
